>>> hdl/rrts_pkg.sv
// Package: shared types and constants of the round-robin thread scheduler.
package rrts_pkg;

  localparam int MAX_THREADS = 16;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_JOIN   = 3'd2,
    CMD_YIELD  = 3'd3,
    CMD_EXIT   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UNUSED  = 3'd0,
    ST_READY   = 3'd1,
    ST_RUNNING = 3'd2,
    ST_BLOCKED = 3'd3,
    ST_YIELDED = 3'd4,
    ST_DONE    = 3'd5
  } status_t;

  localparam logic [1:0] CFG_QUANTUM    = 2'd0;
  localparam logic [1:0] CFG_STACK_BASE = 2'd1;
  localparam logic [1:0] CFG_SLOT_BYTES = 2'd2;
  localparam logic [1:0] CFG_FLOOR      = 2'd3;

  localparam logic [15:0] RST_QUANTUM    = 16'd100;
  localparam logic [15:0] RST_STACK_BASE = 16'd61440;
  localparam logic [15:0] RST_SLOT_BYTES = 16'd1024;
  localparam logic [15:0] RST_FLOOR      = 16'd32768;

  // Result fields that leave the sequencer for the output register.
  typedef struct packed {
    logic [4:0]  running_id;
    logic [4:0]  previous_id;
    logic        switched;
    logic        halted;
    logic [4:0]  new_thread_id;
    logic [15:0] new_stack_top;
    logic [15:0] new_entry;
    logic        join_accepted;
  } result_t;

endpackage

>>> hdl/rrts_slot_calc.sv
// Stack top unit: base minus slot index times slot size, registered, with floor check.
module rrts_slot_calc
  import rrts_pkg::*;
#(
  parameter int SW = 4
) (
  input  logic          clk,
  input  logic [SW-1:0] slot,
  input  logic [15:0]   stack_base,
  input  logic [15:0]   slot_bytes,
  input  logic [15:0]   stack_floor,
  output logic [15:0]   top,
  output logic          fits
);
  logic [SW+15:0] prod_r;
  logic signed [SW+17:0] diff;

  always_ff @(posedge clk) begin
    prod_r <= SW'(slot) * (SW+16)'(slot_bytes);
  end

  assign diff = $signed({2'b00, {SW{1'b0}}, stack_base}) - $signed({2'b00, prod_r});
  assign top  = diff[15:0];
  assign fits = diff >= $signed({2'b00, {SW{1'b0}}, stack_floor});
endmodule

>>> hdl/round_robin_thread_scheduler.sv
// Top level: round-robin thread scheduler with a sequencer that walks threads and queue entries.
//
//  channel | ports                                   | handshake
//  input   | in_command/cycle_now/target_id/entry    | start & !busy
//  config  | cfg_index, cfg_data                     | cfg_valid & cfg_ready
//  result  | out_* fields                            | out_strobe, one cycle
//
// A tick without a switch, a yield and an exit go from the dispatch state through the done
// state to the result. A switch pops and checks one queue entry per pop and evaluate state
// pair. Join scans the queue one entry per cycle. Create checks each slot candidate against
// every thread, one per cycle. busy drops in the result cycle.
// Reset is synchronous (rst_n low); thread 1 runs after it. The receiver cannot stall.
module round_robin_thread_scheduler
  import rrts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_cycle_now,
  input  logic [7:0]  in_target_id,
  input  logic [15:0] in_entry_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_strobe,
  output logic [4:0]  out_running_id,
  output logic [4:0]  out_previous_id,
  output logic        out_switched,
  output logic        out_halted,
  output logic [4:0]  out_new_thread_id,
  output logic [15:0] out_new_stack_top,
  output logic [15:0] out_new_entry,
  output logic        out_join_accepted
);
  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int TW = CW;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_JOIN_SCAN, S_CR_SCAN, S_CR_CALC, S_CR_CHECK,
    S_SW_POP, S_SW_EVAL, S_DONE
  } state_t;

  state_t state_r;
  logic [15:0] quantum_r, base_r, slot_bytes_r, floor_r;
  status_t status_r [MAX_THREADS];
  logic [TW-1:0] wait_r [MAX_THREADS];
  logic [IW-1:0] slot_r [MAX_THREADS];
  logic [MAX_THREADS-1:0] term_r;
  logic [TW-1:0] fifo_r [MAX_THREADS];
  logic [IW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [TW-1:0] cur_r, total_r;
  logic [31:0] last_r, begin_r;
  logic halt_r;

  logic [2:0]  cmd_r;
  logic [31:0] now_r;
  logic [7:0]  tgt_r;
  logic [15:0] entry_r;
  logic [CW-1:0] i_r, n_r;
  logic [CW-1:0] k_r;
  logic hit_r;
  logic [TW-1:0] pop_r;
  logic [TW-1:0] prev_r;
  result_t res_r;
  logic strobe_r;

  logic [15:0] top;
  logic fits;
  logic [IW-1:0] ci, ii, fidx, tail;
  logic [IW-1:0] px;
  logic tgt_ok, tgt_done;
  logic [31:0] elapsed;
  logic live_i;

  assign ci   = IW'(cur_r - TW'(1));
  assign ii   = i_r[IW-1:0];
  assign fidx = IW'(head_r + ii);
  assign tail = IW'(head_r + count_r[IW-1:0]);
  assign px   = IW'(pop_r - TW'(1));
  assign tgt_ok = (tgt_r != 8'd0) && ({1'b0, tgt_r} <= 9'(MAX_THREADS));
  assign tgt_done = tgt_ok && term_r[IW'(tgt_r - 8'd1)];
  assign elapsed = last_r - begin_r;
  assign live_i = (TW'(i_r) + TW'(1) == cur_r) ||
                  (status_r[ii] != ST_UNUSED && status_r[ii] != ST_DONE);

  rrts_slot_calc #(.SW(CW)) u_calc (
    .clk(clk), .slot(k_r), .stack_base(base_r), .slot_bytes(slot_bytes_r),
    .stack_floor(floor_r), .top(top), .fits(fits)
  );

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      quantum_r <= RST_QUANTUM; base_r <= RST_STACK_BASE;
      slot_bytes_r <= RST_SLOT_BYTES; floor_r <= RST_FLOOR;
      for (int t = 0; t < MAX_THREADS; t++) begin
        status_r[t] <= (t == 0) ? ST_RUNNING : ST_UNUSED;
        wait_r[t] <= '0;
        slot_r[t] <= '0;
      end
      term_r <= '0; head_r <= '0; count_r <= '0;
      cur_r <= TW'(1); total_r <= TW'(1);
      last_r <= '0; begin_r <= '0; halt_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (state_r == S_DONE);
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_QUANTUM:    quantum_r <= cfg_data;
          CFG_STACK_BASE: base_r <= cfg_data;
          CFG_SLOT_BYTES: slot_bytes_r <= cfg_data;
          CFG_FLOOR:      floor_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_command; now_r <= in_cycle_now;
            tgt_r <= in_target_id; entry_r <= in_entry_address;
            res_r <= '0; prev_r <= cur_r;
            i_r <= '0; k_r <= '0; hit_r <= 1'b0;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_r <= S_DONE;
          if (!halt_r) begin
            priority case (cmd_r)
              CMD_TICK: begin
                // now_r keeps the previous stamp; a switch starts the turn there
                last_r <= now_r;
                now_r <= last_r;
                if (count_r != '0 && (status_r[ci] == ST_BLOCKED ||
                    status_r[ci] == ST_DONE || elapsed > 32'(quantum_r))) begin
                  if (status_r[ci] == ST_DONE) begin
                    term_r[ci] <= 1'b1;
                    n_r <= count_r;
                  end else begin
                    if (status_r[ci] != ST_BLOCKED) status_r[ci] <= ST_READY;
                    if (count_r < CW'(MAX_THREADS)) begin
                      fifo_r[tail] <= cur_r;
                      count_r <= count_r + CW'(1);
                      n_r <= count_r + CW'(1);
                    end else begin
                      n_r <= count_r;
                    end
                  end
                  i_r <= '0;
                  state_r <= S_SW_POP;
                end else if (count_r == '0 && status_r[ci] == ST_DONE) begin
                  halt_r <= 1'b1;
                end
              end
              CMD_CREATE: begin
                if (total_r < TW'(MAX_THREADS)) state_r <= S_CR_SCAN;
              end
              CMD_JOIN: begin
                if (tgt_done) begin
                  status_r[ci] <= ST_BLOCKED; wait_r[ci] <= TW'(tgt_r);
                  res_r.join_accepted <= 1'b1;
                end else if (tgt_ok && count_r != '0) begin
                  state_r <= S_JOIN_SCAN;
                end
              end
              CMD_YIELD: status_r[ci] <= ST_YIELDED;
              CMD_EXIT:  status_r[ci] <= ST_DONE;
              default: ;
            endcase
          end
        end
        S_JOIN_SCAN: begin
          if ({{(8-TW){1'b0}}, fifo_r[fidx]} == tgt_r && (8 >= TW)) begin
            status_r[ci] <= ST_BLOCKED; wait_r[ci] <= TW'(tgt_r);
            res_r.join_accepted <= 1'b1;
            state_r <= S_DONE;
          end else if (i_r + CW'(1) >= count_r) begin
            state_r <= S_DONE;
          end
          i_r <= i_r + CW'(1);
        end
        S_CR_SCAN: begin
          // i_r walks threads; k_r is the slot candidate
          if (TW'(i_r) < total_r && live_i && CW'(slot_r[ii]) == k_r) begin
            hit_r <= 1'b1;
          end
          if (TW'(i_r) + TW'(1) >= total_r) begin
            i_r <= '0;
            if ((hit_r || (live_i && CW'(slot_r[ii]) == k_r)) &&
                k_r + CW'(1) < CW'(MAX_THREADS)) begin
              k_r <= k_r + CW'(1);
              hit_r <= 1'b0;
            end else begin
              if (hit_r || (live_i && CW'(slot_r[ii]) == k_r)) k_r <= CW'(MAX_THREADS);
              state_r <= S_CR_CALC;
            end
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_CR_CALC: state_r <= S_CR_CHECK;
        S_CR_CHECK: begin
          if (fits) begin
            status_r[IW'(total_r)] <= ST_READY;
            wait_r[IW'(total_r)] <= '0;
            slot_r[IW'(total_r)] <= IW'(k_r);
            total_r <= total_r + TW'(1);
            if (count_r < CW'(MAX_THREADS)) begin
              fifo_r[tail] <= total_r + TW'(1);
              count_r <= count_r + CW'(1);
            end
            res_r.new_thread_id <= 5'(total_r + TW'(1));
            res_r.new_stack_top <= top;
            res_r.new_entry <= entry_r;
          end
          state_r <= S_DONE;
        end
        S_SW_POP: begin
          if (i_r >= n_r) begin
            halt_r <= 1'b1;
            state_r <= S_DONE;
          end else begin
            pop_r <= fifo_r[head_r];
            head_r <= IW'(head_r + IW'(1));
            count_r <= count_r - CW'(1);
            i_r <= i_r + CW'(1);
            state_r <= S_SW_EVAL;
          end
        end
        S_SW_EVAL: begin
          state_r <= S_SW_POP;
          if (pop_r != '0 && CW'(pop_r) <= CW'(MAX_THREADS)) begin
            if (status_r[px] == ST_BLOCKED && !(wait_r[px] != '0 &&
                term_r[IW'(wait_r[px] - TW'(1))])) begin
              fifo_r[tail] <= pop_r;
              count_r <= count_r + CW'(1);
            end else begin
              if (status_r[px] == ST_BLOCKED) wait_r[px] <= '0;
              status_r[px] <= ST_RUNNING;
              begin_r <= now_r;
              cur_r <= pop_r;
              res_r.switched <= 1'b1;
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          res_r.running_id <= 5'(cur_r);
          res_r.previous_id <= res_r.switched ? 5'(prev_r) : 5'(cur_r);
          res_r.halted <= halt_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_strobe        = strobe_r;
  assign out_running_id    = res_r.running_id;
  assign out_previous_id   = res_r.previous_id;
  assign out_switched      = res_r.switched;
  assign out_halted        = res_r.halted;
  assign out_new_thread_id = res_r.new_thread_id;
  assign out_new_stack_top = res_r.new_stack_top;
  assign out_new_entry     = res_r.new_entry;
  assign out_join_accepted = res_r.join_accepted;

`ifndef SYNTH
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe held");
  a_busy_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (out_strobe && !busy)) else $error("missing result");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(halt_r) && rst_n && $past(rst_n) |-> halt_r) else $error("halt cleared");
`endif
endmodule

>>> dv/round_robin_thread_scheduler_test.sv
// Testbench: round-robin thread scheduler checked against a cycle-free scheduler model.
`timescale 1ns / 100ps

module round_robin_thread_scheduler_test
  import rrts_pkg::*;
();

  localparam int NTHREADS = MAX_THREADS;
  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_command = '0;
  logic [31:0] in_cycle_now = '0;
  logic [7:0]  in_target_id = '0;
  logic [15:0] in_entry_address = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        out_strobe;
  logic [4:0]  out_running_id;
  logic [4:0]  out_previous_id;
  logic        out_switched;
  logic        out_halted;
  logic [4:0]  out_new_thread_id;
  logic [15:0] out_new_stack_top;
  logic [15:0] out_new_entry;
  logic        out_join_accepted;

  round_robin_thread_scheduler DUT (.*);

  always #5 clk = ~clk;

  // scheduler model state
  status_t     sched_status [NTHREADS];
  logic [4:0]  sched_wait [NTHREADS];
  logic [3:0]  sched_slot [NTHREADS];
  logic [15:0] done_mask;
  logic [4:0]  runq [NTHREADS];
  int          runq_head, runq_count, cur_id, id_total;
  logic [31:0] last_now, turn_start;
  bit          halted_st;
  logic [15:0] cfg_quantum, cfg_base, cfg_bytes, cfg_floor;

  result_t     expected_q[$];
  int          errors = 0;
  int          stall_cycles = 0;
  bit          idle_on = 1'b1;
  logic [31:0] now_ctr = '0;

  function automatic bit id_ok(int id);
    return id >= 1 && id <= NTHREADS;
  endfunction

  function automatic bit id_done(int id);
    return id_ok(id) && done_mask[id-1];
  endfunction

  function automatic bit id_queued(int id);
    for (int i = 0; i < runq_count; i++)
      if (runq[(runq_head + i) % NTHREADS] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void runq_push(int id);
    if (runq_count < NTHREADS) begin
      runq[(runq_head + runq_count) % NTHREADS] = id[4:0];
      runq_count++;
    end
  endfunction

  function automatic int runq_pop();
    int id;
    id = int'(runq[runq_head]);
    runq_head = (runq_head + 1) % NTHREADS;
    runq_count--;
    return id;
  endfunction

  function automatic bit slot_taken(int k);
    bit live;
    for (int i = 0; i < id_total && i < NTHREADS; i++) begin
      live = (i + 1 == cur_id) ||
             (sched_status[i] != ST_UNUSED && sched_status[i] != ST_DONE);
      if (live && sched_slot[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit switch_thread();
    int ci, n, id;
    ci = cur_id - 1;
    if (sched_status[ci] == ST_DONE) done_mask[ci] = 1'b1;
    else if (sched_status[ci] == ST_BLOCKED) runq_push(cur_id);
    else begin
      sched_status[ci] = ST_READY;
      runq_push(cur_id);
    end
    n = runq_count;
    for (int t = 0; t < n; t++) begin
      id = runq_pop();
      if (!id_ok(id)) continue;
      if (sched_status[id-1] == ST_BLOCKED) begin
        if (!id_done(sched_wait[id-1])) begin
          runq_push(id);
          continue;
        end
        sched_wait[id-1] = '0;
      end
      sched_status[id-1] = ST_RUNNING;
      turn_start = last_now;
      cur_id = id;
      return 1'b1;
    end
    halted_st = 1'b1;
    return 1'b0;
  endfunction

  function automatic void sched_reset();
    foreach (sched_status[i]) begin
      sched_status[i] = ST_UNUSED;
      sched_wait[i] = '0;
      sched_slot[i] = '0;
      runq[i] = '0;
    end
    sched_status[0] = ST_RUNNING;
    done_mask = '0;
    runq_head = 0;
    runq_count = 0;
    cur_id = 1;
    id_total = 1;
    last_now = '0;
    turn_start = '0;
    halted_st = 1'b0;
    cfg_quantum = RST_QUANTUM;
    cfg_base = RST_STACK_BASE;
    cfg_bytes = RST_SLOT_BYTES;
    cfg_floor = RST_FLOOR;
  endfunction

  function automatic result_t schedule_request(logic [2:0] cmd, logic [31:0] now,
                                               logic [7:0] tgt, logic [15:0] entry);
    result_t r;
    int prev, ci, k, top, x;
    bit sw;
    logic [31:0] used;
    r = '0;
    sw = 1'b0;
    prev = cur_id;
    ci = cur_id - 1;
    if (!halted_st) begin
      case (cmd)
        CMD_TICK: begin
          used = last_now - turn_start;
          if (runq_count > 0 && (sched_status[ci] == ST_BLOCKED ||
              sched_status[ci] == ST_DONE || used > cfg_quantum)) begin
            sw = switch_thread();
          end else if (runq_count == 0 && sched_status[ci] == ST_DONE) begin
            halted_st = 1'b1;
          end
          last_now = now;
        end
        CMD_CREATE: begin
          if (id_total < NTHREADS) begin
            k = 0;
            while (k < NTHREADS && slot_taken(k)) k++;
            top = int'(cfg_base) - k * int'(cfg_bytes);
            if (top >= int'(cfg_floor)) begin
              x = id_total;
              sched_status[x] = ST_READY;
              sched_wait[x] = '0;
              sched_slot[x] = k[3:0];
              id_total++;
              runq_push(id_total);
              r.new_thread_id = id_total[4:0];
              r.new_stack_top = top[15:0];
              r.new_entry = entry;
            end
          end
        end
        CMD_JOIN: begin
          if (id_ok(tgt) && (id_queued(tgt) || id_done(tgt))) begin
            sched_status[ci] = ST_BLOCKED;
            sched_wait[ci] = tgt[4:0];
            r.join_accepted = 1'b1;
          end
        end
        CMD_YIELD: sched_status[ci] = ST_YIELDED;
        CMD_EXIT:  sched_status[ci] = ST_DONE;
        default: ;
      endcase
    end
    r.running_id = cur_id[4:0];
    r.previous_id = sw ? prev[4:0] : cur_id[4:0];
    r.switched = sw;
    r.halted = halted_st;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_strobe) begin
      stall_cycles = 0;
      if (expected_q.size() == 0) begin
        report_mismatch("out_strobe", 1, 0);
      end else begin
        e = expected_q.pop_front();
        if (out_running_id !== e.running_id)
          report_mismatch("running_id", out_running_id, e.running_id);
        if (out_previous_id !== e.previous_id)
          report_mismatch("previous_id", out_previous_id, e.previous_id);
        if (out_switched !== e.switched)
          report_mismatch("switched", out_switched, e.switched);
        if (out_halted !== e.halted)
          report_mismatch("halted", out_halted, e.halted);
        if (out_new_thread_id !== e.new_thread_id)
          report_mismatch("new_thread_id", out_new_thread_id, e.new_thread_id);
        if (out_new_stack_top !== e.new_stack_top)
          report_mismatch("new_stack_top", out_new_stack_top, e.new_stack_top);
        if (out_new_entry !== e.new_entry)
          report_mismatch("new_entry", out_new_entry, e.new_entry);
        if (out_join_accepted !== e.join_accepted)
          report_mismatch("join_accepted", out_join_accepted, e.join_accepted);
      end
    end
  end

  always @(posedge clk) begin
    stall_cycles = stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_request(logic [2:0] cmd, logic [31:0] now = now_ctr,
                              logic [7:0] tgt = '0, logic [15:0] entry = '0);
    result_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_cycle_now <= now;
    in_target_id <= tgt;
    in_entry_address <= entry;
    @(posedge clk);
    while (busy) @(posedge clk);
    stall_cycles = 0;
    want = schedule_request(cmd, now, tgt, entry);
    expected_q = {expected_q, want};
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    stall_cycles = 0;
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUANTUM:    cfg_quantum = value;
      CFG_STACK_BASE: cfg_base = value;
      CFG_SLOT_BYTES: cfg_bytes = value;
      CFG_FLOOR:      cfg_floor = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic tick_ahead();
    if ($urandom_range(0, 19) == 0) now_ctr = $urandom;
    else now_ctr = now_ctr + $urandom_range(0, 2 * cfg_quantum + 2);
    send_request(CMD_TICK, now_ctr);
  endtask

  function automatic logic [7:0] pick_join_target();
    int id;
    if ($urandom_range(0, 9) < 2) return 8'($urandom);
    for (int tries = 0; tries < 8; tries++) begin
      id = $urandom_range(1, NTHREADS);
      if (id != cur_id && (id_done(id) ||
          (id_queued(id) && sched_status[id-1] != ST_BLOCKED)))
        return id[7:0];
    end
    return 8'($urandom_range(0, 20));
  endfunction

  task automatic test_register_extremes();
    write_reg(CFG_QUANTUM, 16'd1);
    write_reg(CFG_STACK_BASE, 16'hFFFF);
    write_reg(CFG_SLOT_BYTES, 16'd0);
    write_reg(CFG_FLOOR, 16'hFFFF);
    send_request(CMD_CREATE, now_ctr, 8'h00, 16'hFFFF);
    send_request(CMD_CREATE, now_ctr, 8'hFF, 16'h0000);
    send_request(CMD_TICK, 32'h0000_0000);
    send_request(CMD_TICK, 32'hFFFF_FFFF);
    send_request(CMD_TICK, 32'h0000_0003);
    send_request(3'd5);
    send_request(3'd6);
    send_request(3'd7, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_join_and_exit();
    send_request(CMD_JOIN, now_ctr, 8'd0);
    send_request(CMD_JOIN, now_ctr, 8'd255);
    send_request(CMD_JOIN, now_ctr, 8'(cur_id));
    send_request(CMD_JOIN, now_ctr, 8'd17);
    send_request(CMD_JOIN, now_ctr, 8'(runq[runq_head]));
    send_request(CMD_TICK, 32'd10);
    send_request(CMD_YIELD);
    send_request(CMD_TICK, 32'd20);
    send_request(CMD_EXIT);
    send_request(CMD_TICK, 32'd30);
    send_request(CMD_TICK, 32'd40);
    now_ctr = 32'd40;
  endtask

  task automatic test_stack_exhaustion();
    drain();
    write_reg(CFG_FLOOR, 16'd0);
    write_reg(CFG_STACK_BASE, 16'd3000);
    write_reg(CFG_SLOT_BYTES, 16'd32768);
    send_request(CMD_CREATE, now_ctr, 8'd0, 16'h1234);
    send_request(CMD_CREATE, now_ctr, 8'd0, 16'h4321);
    drain();
    write_reg(CFG_STACK_BASE, RST_STACK_BASE);
    write_reg(CFG_SLOT_BYTES, RST_SLOT_BYTES);
    write_reg(CFG_FLOOR, RST_FLOOR);
  endtask

  task automatic test_random_traffic(int items, logic [15:0] quantum);
    int r;
    logic [15:0] base;
    drain();
    base = 16'($urandom_range(16384, 65535));
    write_reg(CFG_QUANTUM, quantum);
    write_reg(CFG_STACK_BASE, base);
    write_reg(CFG_SLOT_BYTES, 16'($urandom_range(1, 4096)));
    write_reg(CFG_FLOOR, 16'($urandom_range(0, base / 2)));
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) tick_ahead();
      else if (r < 58) send_request(CMD_CREATE, $urandom, 8'($urandom), 16'($urandom));
      else if (r < 73) send_request(CMD_JOIN, $urandom, pick_join_target());
      else if (r < 83) send_request(CMD_YIELD, $urandom);
      else if (r < 93 && runq_count >= 2) send_request(CMD_EXIT, $urandom);
      else if (r < 96) send_request(3'($urandom_range(5, 7)), $urandom, 8'($urandom));
      else tick_ahead();
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  task automatic test_halt();
    idle_on = 1'b0;
    repeat (10) begin
      if (runq_count > 0)
        send_request(CMD_JOIN, now_ctr, 8'(runq[runq_head]));
      now_ctr = now_ctr + 32'd70000;
      send_request(CMD_TICK, now_ctr);
    end
    repeat (40) begin
      send_request(CMD_EXIT);
      now_ctr = now_ctr + 32'd70000;
      send_request(CMD_TICK, now_ctr);
    end
    send_request(CMD_CREATE, now_ctr, 8'd0, 16'hBEEF);
    send_request(CMD_JOIN, now_ctr, 8'd1);
  endtask

  initial begin
    sched_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_extremes();
    test_join_and_exit();
    test_stack_exhaustion();
    test_random_traffic(160, 16'd65535);
    test_random_traffic(160, 16'd1);
    test_random_traffic(160, 16'($urandom_range(2, 500)));
    idle_on = 1'b0;
    test_random_traffic(50, 16'd200);
    test_halt();
    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
